### design/qbts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbts_pkg: shared types and constants of the quad batcher
// Field layouts of the stream payloads, the internal job record and the
// pixel rounding and saturating depth add helpers used by the front end.
// ----------------------------------------------------------------------------
package qbts_pkg;

    localparam int MAX_QUADS  = 256;
    localparam int TEX_SLOTS  = 8;
    localparam int SLOT_W     = 3;   // slot index width (output field)
    localparam int SLOT_CNT_W = 4;   // slot count, holds TEX_SLOTS itself
    localparam int QCNT_W     = 9;   // quad count, holds MAX_QUADS itself
    localparam int CORNERS    = 4;
    localparam int CORNER_W   = 2;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 184;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_STEP    = 2'd2;

    localparam logic [12:0]        SCREEN_HEIGHT_RST = 13'd1080;
    localparam logic signed [15:0] DEPTH_START_RST   = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_STEP_RST    = -16'sd1;

    typedef enum logic [1:0] {
        KIND_VERTEX     = 2'd0,
        KIND_DRAW       = 2'd1,
        KIND_FULL_QUADS = 2'd2,
        KIND_FULL_SLOTS = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        CMD_ADD   = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // input payload, last field in the lowest bits
    typedef struct packed {
        logic [63:0]        rgba;
        logic signed [15:0] tex_v_bottom;
        logic signed [15:0] tex_u_right;
        logic signed [15:0] tex_v_top;
        logic signed [15:0] tex_u_left;
        logic signed [17:0] rect_bottom;
        logic signed [17:0] rect_right;
        logic signed [17:0] rect_top;
        logic signed [17:0] rect_left;
        logic [31:0]        texture_id;
    } t_in_data;

    // result payload, last field in the lowest bits
    typedef struct packed {
        logic [8:0]         quads_in_batch;
        logic [31:0]        slot_texture;
        logic [63:0]        color_out;
        logic [SLOT_W-1:0]  slot;
        logic signed [15:0] vertex_v;
        logic signed [15:0] vertex_u;
        logic signed [15:0] depth;
        logic signed [13:0] vertex_y;
        logic signed [13:0] vertex_x;
    } t_result;

    // one classified item as it waits between front and back end
    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic signed [13:0] x0;
        logic signed [13:0] x1;
        logic signed [13:0] y0;
        logic signed [13:0] y1;
        logic signed [15:0] depth;
        logic signed [15:0] u0;
        logic signed [15:0] u1;
        logic signed [15:0] v0;
        logic signed [15:0] v1;
        logic [SLOT_W-1:0]  slot;
        logic [63:0]        color;
        logic [31:0]        stex;
        logic [QCNT_W-1:0]  quads;
    } t_job;

    // floor(v / 16), saturated to signed 14 bits
    function automatic logic signed [13:0] px_round(input logic signed [20:0] v);
        logic signed [20:0] q;
        q = v >>> 4;
        if (q > 21'sd8191) begin
            return 14'sd8191;
        end else if (q < -21'sd8192) begin
            return -14'sd8192;
        end
        return q[13:0];
    endfunction

    function automatic logic signed [15:0] sat16_add(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        if (s > 17'sd32767) begin
            return 16'sh7FFF;
        end else if (s < -17'sd32768) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

endpackage
`default_nettype wire

### design/qbts_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbts_fifo: job queue between front and back end
// Small register queue; decouples classification from result expansion.
// ----------------------------------------------------------------------------
module qbts_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  qbts_pkg::t_job         i_wdata,
    output logic                   o_full,
    input  wire logic              i_pop,
    output qbts_pkg::t_job         o_rdata,
    output logic                   o_empty
);
    import qbts_pkg::*;

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job queue read while empty");

endmodule
`default_nettype wire

### design/qbts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbts_front: command intake, slot lookup and batch state
// Accepts add and flush commands, owns the slot table, counters, running
// depth and configuration, and queues one job per result group.
// ----------------------------------------------------------------------------
module qbts_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [qbts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [qbts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_cmd,
    input  qbts_pkg::t_in_data                     i_data,
    output logic                                   o_push,
    output qbts_pkg::t_job                         o_job,
    input  wire logic                              i_full
);
    import qbts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } t_front_state;

    t_front_state            r_state, n_state;
    logic [12:0]             r_screen_height;
    logic signed [15:0]      r_depth_start;
    logic signed [15:0]      r_depth_step;
    logic signed [15:0]      r_depth, n_depth;
    logic [QCNT_W-1:0]       r_quad_count, n_quad_count;
    logic [SLOT_CNT_W-1:0]   r_slots_used, n_slots_used;
    logic [SLOT_W-1:0]       r_fidx, n_fidx;
    logic [31:0]             r_slot_table [TEX_SLOTS];

    logic                    w_accept;
    logic                    w_hit;
    logic [SLOT_W-1:0]       w_hit_slot;
    logic                    w_tab_we;
    logic [SLOT_W-1:0]       w_tab_idx;
    logic                    w_flush_last;
    logic signed [20:0]      w_h16;

    assign o_ready  = (r_state == ST_IDLE) && !i_full;
    assign w_accept = o_ready && i_valid;
    assign w_h16    = $signed({4'b0000, r_screen_height, 4'b0000});
    assign w_flush_last = ({1'b0, r_fidx} + 1'b1) == r_slots_used;
    assign w_tab_idx    = r_slots_used[SLOT_W-1:0];

    // match against occupied slots, lowest slot wins
    always_comb begin
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int i = TEX_SLOTS - 1; i >= 0; i--) begin
            if ((SLOT_CNT_W'(i) < r_slots_used) && (r_slot_table[i] == i_data.texture_id)) begin
                w_hit      = 1'b1;
                w_hit_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_quad_count = r_quad_count;
        n_slots_used = r_slots_used;
        n_fidx       = r_fidx;
        o_push       = 1'b0;
        o_job        = '0;
        w_tab_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_FLUSH) begin
                        // empty flush: drop silently
                        if (r_quad_count != '0) begin
                            n_state = ST_FLUSH;
                            n_fidx  = '0;
                        end
                    end else if (r_quad_count >= QCNT_W'(MAX_QUADS)) begin
                        o_push      = 1'b1;
                        o_job.kind  = KIND_FULL_QUADS;
                        o_job.last  = 1'b1;
                    end else if (!w_hit && (r_slots_used >= SLOT_CNT_W'(TEX_SLOTS))) begin
                        o_push      = 1'b1;
                        o_job.kind  = KIND_FULL_SLOTS;
                        o_job.last  = 1'b1;
                    end else begin
                        o_push      = 1'b1;
                        o_job.kind  = KIND_VERTEX;
                        o_job.last  = 1'b1;
                        o_job.x0    = px_round(21'(i_data.rect_left) + 21'sd8);
                        o_job.x1    = px_round(21'(i_data.rect_right) + 21'sd8);
                        o_job.y0    = px_round(w_h16 - 21'(i_data.rect_top) - 21'sd8);
                        o_job.y1    = px_round(w_h16 - 21'(i_data.rect_bottom) - 21'sd8);
                        o_job.depth = r_depth;
                        o_job.u0    = i_data.tex_u_left;
                        o_job.u1    = i_data.tex_u_right;
                        o_job.v0    = i_data.tex_v_top;
                        o_job.v1    = i_data.tex_v_bottom;
                        o_job.slot  = w_hit ? w_hit_slot : w_tab_idx;
                        o_job.color = i_data.rgba;
                        if (!w_hit) begin
                            w_tab_we     = 1'b1;
                            n_slots_used = r_slots_used + 1'b1;
                        end
                        n_quad_count = r_quad_count + 1'b1;
                        n_depth      = sat16_add(r_depth, r_depth_step);
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_full) begin
                    o_push      = 1'b1;
                    o_job.kind  = KIND_DRAW;
                    o_job.last  = w_flush_last;
                    o_job.slot  = r_fidx;
                    o_job.stex  = r_slot_table[r_fidx];
                    o_job.quads = r_quad_count;
                    if (w_flush_last) begin
                        n_state      = ST_IDLE;
                        n_quad_count = '0;
                        n_slots_used = '0;
                        n_depth      = r_depth_start;
                    end else begin
                        n_fidx = r_fidx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_slot_table[w_tab_idx] <= i_data.texture_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_screen_height <= SCREEN_HEIGHT_RST;
            r_depth_start   <= DEPTH_START_RST;
            r_depth_step    <= DEPTH_STEP_RST;
            r_depth         <= DEPTH_START_RST;
            r_quad_count    <= '0;
            r_slots_used    <= '0;
            r_fidx          <= '0;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_quad_count <= n_quad_count;
            r_slots_used <= n_slots_used;
            r_fidx       <= n_fidx;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[12:0];
                    REG_DEPTH_START:   r_depth_start   <= $signed(i_cfg_data);
                    REG_DEPTH_STEP:    r_depth_step    <= $signed(i_cfg_data);
                    default:           r_depth_step    <= r_depth_step;
                endcase
            end
        end
    end

    a_slots_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots_used <= SLOT_CNT_W'(TEX_SLOTS)) else $error("slot count overran table");
    a_empty_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_quad_count == '0) |-> (r_slots_used == '0))
        else $error("slots held by an empty batch");
    a_flush_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> ({1'b0, r_fidx} < r_slots_used))
        else $error("flush walked past occupied slots");

endmodule
`default_nettype wire

### design/qbts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbts_back: result expansion and output register
// Pops one job at a time, expands an add into four corners and drives the
// registered result stream.
// ----------------------------------------------------------------------------
module qbts_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  qbts_pkg::t_job   i_job,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_tvalid,
    input  wire logic        i_tready,
    output qbts_pkg::t_result o_tdata,
    output qbts_pkg::t_kind  o_tuser,
    output logic             o_tlast
);
    import qbts_pkg::*;

    t_job                r_job;
    logic                r_busy;
    logic [CORNER_W-1:0] r_k;
    logic                r_ovalid;
    t_result             r_odata;
    t_kind               r_okind;
    logic                r_olast;

    logic                w_emit;
    logic                w_fin;
    logic                w_last_corner;
    logic                w_left;
    logic                w_top;
    t_result             w_res;

    assign w_last_corner = (r_k == CORNER_W'(CORNERS - 1));
    assign w_emit = r_busy && (!r_ovalid || i_tready);
    assign w_fin  = w_emit && ((r_job.kind != KIND_VERTEX) || w_last_corner);
    assign o_pop  = !i_empty && (!r_busy || w_fin);

    // corner order: top-left, top-right, bottom-right, bottom-left
    assign w_left = (r_k == 2'd0) || (r_k == 2'd3);
    assign w_top  = (r_k == 2'd0) || (r_k == 2'd1);

    always_comb begin
        w_res                = '0;
        w_res.vertex_x       = w_left ? r_job.x0 : r_job.x1;
        w_res.vertex_y       = w_top  ? r_job.y0 : r_job.y1;
        w_res.vertex_u       = w_left ? r_job.u0 : r_job.u1;
        w_res.vertex_v       = w_top  ? r_job.v0 : r_job.v1;
        w_res.depth          = r_job.depth;
        w_res.slot           = r_job.slot;
        w_res.color_out      = r_job.color;
        w_res.slot_texture   = r_job.stex;
        w_res.quads_in_batch = r_job.quads;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_odata <= w_res;
            r_okind <= r_job.kind;
            r_olast <= (r_job.kind == KIND_VERTEX) ? w_last_corner : r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else begin
                if (w_fin) begin
                    r_busy <= 1'b0;
                end
                // advance the corner only for vertex jobs; it wraps after the last
                if (w_emit && (r_job.kind == KIND_VERTEX)) begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_okind;
    assign o_tlast  = r_olast;

    a_corner_only_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0) |-> (r_busy && (r_job.kind == KIND_VERTEX)))
        else $error("corner count advanced outside a vertex job");

endmodule
`default_nettype wire

### design/quad_batcher_texture_slots.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_batcher_texture_slots: textured quad batcher with texture slot table
// Turns add commands into four corner vertices, or one reject when the batch
// is full, and flush commands into one draw entry per occupied texture slot.
// ----------------------------------------------------------------------------
//
//  port group | dir | carries
//  -----------+-----+--------------------------------------------------------
//  s_axis_*   | in  | commands: tuser = cmd, tdata = rectangle fields
//  m_axis_*   | out | results:  tuser = kind, tdata = vertex / draw fields,
//             |     |           tlast = final result of one command
//  i_cfg_*    | in  | register writes: screen height, depth start, depth step
//
// Flow: an add leaves as four result transfers, one corner per cycle from the
// back end while m_axis_tready is held high. A flush occupies the front end
// while it walks the slot table, one occupied slot (1 to 8) per cycle while
// the job queue has room.
// Reset: synchronous, active low; clears counters and reloads default
// registers. The slot table holds no reset value and needs no clearing.
// Stalls: a two-entry job queue sits between front and back end; the front
// end keeps taking commands while results wait on m_axis_tready, until the
// queue fills. An empty flush yields nothing.
//
module quad_batcher_texture_slots (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration writes
    input  wire logic                                 i_cfg_we,
    input  wire logic [qbts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [qbts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // command stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata, low bit up: texture_id, rect_left, rect_top, rect_right,
    // rect_bottom, tex_u_left, tex_v_top, tex_u_right, tex_v_bottom, rgba
    input  wire logic [qbts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: cmd
    input  wire logic                                 s_axis_tuser,
    // result stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata, low bit up: vertex_x, vertex_y, depth, vertex_u, vertex_v, slot,
    // color_out, slot_texture, quads_in_batch
    output logic [qbts_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // tuser: kind
    output logic [1:0]                                m_axis_tuser,
    output logic                                      m_axis_tlast
);
    import qbts_pkg::*;

    t_in_data w_in_data;
    t_job     w_push_job;
    t_job     w_pop_job;
    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_result  w_out_data;
    t_kind    w_out_kind;

    assign w_in_data = t_in_data'(s_axis_tdata);

    // front end: classify commands, track batch state, queue jobs
    qbts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_data      (w_in_data),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    // hold classified jobs so either side may stall on its own
    qbts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_pop_job),
        .o_empty (w_empty)
    );

    // back end: expand jobs into result transfers
    qbts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_pop_job),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (w_out_data),
        .o_tuser  (w_out_kind),
        .o_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_out_data);
    assign m_axis_tuser = 2'(w_out_kind);

endmodule
`default_nettype wire

### tb/sv/quad_batcher_texture_slots_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_batcher_texture_slots_checker: result predictor and scoreboard
// Tracks the slot table, quad count and running depth of the batcher from
// the accepted command and register traffic, and compares every result
// transfer field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module quad_batcher_texture_slots_checker
    import qbts_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_s_tvalid,
    input  wire logic                    i_s_tready,
    // tdata, low bit up: texture_id, rect_left, rect_top, rect_right,
    // rect_bottom, tex_u_left, tex_v_top, tex_u_right, tex_v_bottom, rgba
    input  wire logic [IN_TDATA_W-1:0]   i_s_tdata,
    // tuser: cmd
    input  wire logic                    i_s_tuser,
    input  wire logic                    i_m_tvalid,
    input  wire logic                    i_m_tready,
    // tdata, low bit up: vertex_x, vertex_y, depth, vertex_u, vertex_v, slot,
    // color_out, slot_texture, quads_in_batch
    input  wire logic [OUT_TDATA_W-1:0]  i_m_tdata,
    // tuser: kind
    input  wire logic [1:0]              i_m_tuser,
    input  wire logic                    i_m_tlast,
    output int                           o_err_count,
    output int                           o_pending
);

    typedef struct packed {
        t_kind   kind;
        logic    last;
        t_result fields;
    } t_batch_out;

    t_batch_out         batch_outputs [$];
    int                 error_total;

    logic [31:0]        slot_tex [TEX_SLOTS];
    int                 slots_used;
    int                 quads_held;
    logic signed [15:0] cur_depth;
    logic [12:0]        scr_height;
    logic signed [15:0] start_depth;
    logic signed [15:0] step_depth;

    // floor(v / 16) clamped to the signed 14 bit pixel range
    function automatic logic signed [13:0] floor_px16(input int v);
        int q;
        q = v >>> 4;
        if (q > 8191) q = 8191;
        if (q < -8192) q = -8192;
        return q[13:0];
    endfunction

    task automatic push_reject(input t_kind k);
        t_batch_out r;
        r = '0;
        r.kind = k;
        r.last = 1'b1;
        batch_outputs.push_back(r);
    endtask

    task automatic predict_command(input t_cmd c, input t_in_data d);
        t_batch_out         r;
        int                 hit;
        int                 h16;
        int                 i;
        int                 sum;
        logic signed [13:0] xl, xr, yt, yb;
        if (c == CMD_FLUSH) begin
            // empty batch: nothing leaves and the depth is not reloaded
            if (quads_held == 0) return;
            for (i = 0; i < slots_used; i++) begin
                r = '0;
                r.kind = KIND_DRAW;
                r.fields.slot = i[SLOT_W-1:0];
                r.fields.slot_texture = slot_tex[i];
                r.fields.quads_in_batch = quads_held[8:0];
                r.last = (i == slots_used - 1);
                batch_outputs.push_back(r);
            end
            quads_held = 0;
            slots_used = 0;
            cur_depth = start_depth;
            return;
        end
        // quad store full wins over the slot check
        if (quads_held >= MAX_QUADS) begin
            push_reject(KIND_FULL_QUADS);
            return;
        end
        hit = -1;
        for (i = 0; i < slots_used; i++) begin
            if (hit < 0 && slot_tex[i] == d.texture_id) hit = i;
        end
        if (hit < 0) begin
            if (slots_used >= TEX_SLOTS) begin
                push_reject(KIND_FULL_SLOTS);
                return;
            end
            hit = slots_used;
            slot_tex[hit] = d.texture_id;
            slots_used++;
        end
        h16 = int'(scr_height) * 16;
        xl = floor_px16(int'(d.rect_left) + 8);
        xr = floor_px16(int'(d.rect_right) + 8);
        yt = floor_px16(h16 - int'(d.rect_top) - 8);
        yb = floor_px16(h16 - int'(d.rect_bottom) - 8);
        // corners: top-left, top-right, bottom-right, bottom-left
        for (i = 0; i < CORNERS; i++) begin
            r = '0;
            r.kind = KIND_VERTEX;
            r.fields.vertex_x = (i == 0 || i == 3) ? xl : xr;
            r.fields.vertex_y = (i < 2) ? yt : yb;
            r.fields.vertex_u = (i == 0 || i == 3) ? d.tex_u_left : d.tex_u_right;
            r.fields.vertex_v = (i < 2) ? d.tex_v_top : d.tex_v_bottom;
            r.fields.depth = cur_depth;
            r.fields.slot = hit[SLOT_W-1:0];
            r.fields.color_out = d.rgba;
            r.last = (i == CORNERS - 1);
            batch_outputs.push_back(r);
        end
        quads_held++;
        sum = int'(cur_depth) + int'(step_depth);
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        cur_depth = sum[15:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            error_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_batch_out want;
        t_result    got;
        if (!i_rst_n) begin
            slots_used = 0;
            quads_held = 0;
            scr_height = SCREEN_HEIGHT_RST;
            start_depth = DEPTH_START_RST;
            step_depth = DEPTH_STEP_RST;
            cur_depth = DEPTH_START_RST;
            batch_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SCREEN_HEIGHT: scr_height = i_cfg_data[12:0];
                    REG_DEPTH_START:   start_depth = i_cfg_data;
                    REG_DEPTH_STEP:    step_depth = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_command(t_cmd'(i_s_tuser), t_in_data'(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata);
                if (batch_outputs.size() == 0) begin
                    $display("%0t: unexpected result transfer, kind %0d tdata %h",
                             $time, i_m_tuser, i_m_tdata);
                    error_total++;
                end else begin
                    want = batch_outputs.pop_front();
                    check_field("kind", want.kind, i_m_tuser);
                    check_field("last", want.last, i_m_tlast);
                    check_field("vertex_x", want.fields.vertex_x, got.vertex_x);
                    check_field("vertex_y", want.fields.vertex_y, got.vertex_y);
                    check_field("depth", want.fields.depth, got.depth);
                    check_field("vertex_u", want.fields.vertex_u, got.vertex_u);
                    check_field("vertex_v", want.fields.vertex_v, got.vertex_v);
                    check_field("slot", want.fields.slot, got.slot);
                    check_field("color_out", want.fields.color_out, got.color_out);
                    check_field("slot_texture", want.fields.slot_texture,
                                got.slot_texture);
                    check_field("quads_in_batch", want.fields.quads_in_batch,
                                got.quads_in_batch);
                end
            end
        end
        o_pending <= batch_outputs.size();
        o_err_count <= error_total;
    end

endmodule

### tb/sv/tb_quad_batcher_texture_slots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_batcher_texture_slots: stimulus and verdict for the quad batcher
// Drives a directed opening and four random phases with different idle and
// stall patterns and register settings; the checker beside the block
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_quad_batcher_texture_slots;
    import qbts_pkg::*;

    // cycles with no transfer at all before the run is declared stuck
    localparam int WATCHDOG_LIMIT = 5000;
    // receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES    = 400;
    localparam int POOL_SIZE      = 10;
    localparam int RANDOM_ITEMS   = 49;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata, low bit up: texture_id, rect_left, rect_top, rect_right,
    // rect_bottom, tex_u_left, tex_v_top, tex_u_right, tex_v_bottom, rgba
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // tuser: cmd
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata, low bit up: vertex_x, vertex_y, depth, vertex_u, vertex_v, slot,
    // color_out, slot_texture, quads_in_batch
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // tuser: kind
    logic [1:0]              m_axis_tuser;
    logic                    m_axis_tlast;

    int err_count;
    int pending;

    // idle percentages of the sender and the receiver for the current phase
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    // hold-off requests from the stimulus, served by the receiver process
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    logic [31:0] tex_pool [POOL_SIZE];
    t_in_data    rect;
    int          roll;

    quad_batcher_texture_slots u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    quad_batcher_texture_slots_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: serve a pending hold-off first, otherwise stall at random.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_asked != hold_given) begin
            hold_given = hold_given + 1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: any transfer or register write resets the quiet count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_quad_batcher_texture_slots: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random rectangle with full-range fields around the given texture id.
    function automatic t_in_data rand_rect(input logic [31:0] tex);
        t_in_data d;
        d.texture_id = tex;
        d.rect_left = 18'($urandom);
        d.rect_top = 18'($urandom);
        d.rect_right = 18'($urandom);
        d.rect_bottom = 18'($urandom);
        d.tex_u_left = 16'($urandom);
        d.tex_v_top = 16'($urandom);
        d.tex_u_right = 16'($urandom);
        d.tex_v_bottom = 16'($urandom);
        d.rgba = {$urandom, $urandom};
        return d;
    endfunction

    // Offer one command after a random gap; return once it transfers.
    task automatic send_cmd(input t_cmd c, input t_in_data d);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain all predicted results, then let a trailing flush walk finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [12:0] height, input logic [15:0] start,
                              input logic [15:0] step);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_SCREEN_HEIGHT;
        i_cfg_data <= {3'b000, height};
        @(negedge i_clk);
        i_cfg_index <= REG_DEPTH_START;
        i_cfg_data <= start;
        @(negedge i_clk);
        i_cfg_index <= REG_DEPTH_STEP;
        i_cfg_data <= step;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part, reset register values ---
        // flush of an empty batch: no transfer expected
        send_cmd(CMD_FLUSH, rand_rect(32'h0));

        // field extremes; x and the top y saturate
        rect = '0;
        rect.texture_id = 32'hFFFF_FFFF;
        rect.rect_left = -18'sd131072;
        rect.rect_top = -18'sd131072;
        rect.rect_right = 18'sd131071;
        rect.rect_bottom = 18'sd131071;
        rect.tex_u_left = -16'sd32768;
        rect.tex_v_top = -16'sd32768;
        rect.tex_u_right = 16'sd32767;
        rect.tex_v_bottom = 16'sd32767;
        rect.rgba = '1;
        send_cmd(CMD_ADD, rect);

        // all zero fields, second slot
        send_cmd(CMD_ADD, '0);

        // rounding just below and at the half pixel, both signs; slot hit
        rect = '0;
        rect.texture_id = 32'hFFFF_FFFF;
        rect.rect_left = 18'sd7;
        rect.rect_right = 18'sd8;
        rect.rect_top = -18'sd9;
        rect.rect_bottom = -18'sd8;
        send_cmd(CMD_ADD, rect);
        rect.rect_left = -18'sd8;
        rect.rect_right = -18'sd9;
        rect.rect_top = 18'sd7;
        rect.rect_bottom = 18'sd8;
        send_cmd(CMD_ADD, rect);

        // fill the slot table, overflow it with a new id, then hit again
        for (int t = 1; t <= 6; t++) send_cmd(CMD_ADD, rand_rect(t));
        send_cmd(CMD_ADD, rand_rect(32'd7));
        send_cmd(CMD_ADD, rand_rect(32'd0));

        // full flush of eight slots, then an empty one
        send_cmd(CMD_FLUSH, rand_rect($urandom));
        send_cmd(CMD_FLUSH, rand_rect($urandom));

        // --- random phases, each with its own idling and registers ---
        for (int mode = 0; mode < 4; mode++) begin
            settle();
            case (mode)
                0: begin
                    // no idling; hold the receiver off so the input backs up
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    write_regs(13'd8191, 16'sd32767, 16'sd32767);
                    hold_asked = hold_asked + 1;
                end
                1: begin
                    src_idle_pct = 81;
                    sink_stall_pct = 0;
                    write_regs(13'd0, -16'sd32768, -16'sd32768);
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 81;
                    write_regs(13'($urandom), 16'($urandom),
                               16'($urandom_range(0, 64) - 32));
                end
                default: begin
                    src_idle_pct = 32;
                    sink_stall_pct = 32;
                    write_regs(13'd1080, 16'sd0, 16'sd1);
                end
            endcase
            for (int p = 0; p < POOL_SIZE; p++) tex_pool[p] = $urandom;
            // mostly adds from a small id pool so batches reuse and overflow
            // slots; a few flushes and stray ids mixed in
            repeat (RANDOM_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    send_cmd(CMD_FLUSH, rand_rect($urandom));
                else if (roll < 13)
                    send_cmd(CMD_ADD, rand_rect($urandom));
                else
                    send_cmd(CMD_ADD, rand_rect(tex_pool[$urandom_range(0, POOL_SIZE - 1)]));
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("tb_quad_batcher_texture_slots: clean");
        end else begin
            $display("tb_quad_batcher_texture_slots: errors");
        end
        $finish;
    end

endmodule
